// ===== hw/rtl/staff_line_run_score_macros.svh =====
// Assertion macros shared by the staff line run score RTL.
`ifndef STAFF_LINE_RUN_SCORE_MACROS_SVH
`define STAFF_LINE_RUN_SCORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SLRS_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
`define SLRS_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`else
`define SLRS_ASSERT(lbl, ck, rn, prop, msg)
`define SLRS_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/slrs_pkg.sv =====
// Shared constants for the staff line run score block.
package slrs_pkg;

    localparam int SUM_W            = 25;
    localparam int CFG_W            = 12;
    localparam int CFG_IDX_W        = 1;
    localparam int MAX_LINE_LEN_DEF = 4096;

    localparam logic [SUM_W-1:0] SUM_CAP = 25'h100_0000;

    localparam logic [CFG_W-1:0] GAP_MIN_RST   = 12'd20;
    localparam logic [CFG_W-1:0] GAP_ABORT_RST = 12'd100;

    localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_ABORT = 1'b1;

endpackage

// ===== hw/rtl/slrs_if.sv =====
// Channel interfaces of the staff line run score block.
interface slrs_pix_if;
    logic valid;
    logic ready;
    logic pixel_mid;
    logic pixel_above;
    logic pixel_below;
    logic last_in_line;
    logic last_in_group;

    modport source (
        output valid, pixel_mid, pixel_above, pixel_below, last_in_line, last_in_group,
        input  ready
    );
    modport sink (
        input  valid, pixel_mid, pixel_above, pixel_below, last_in_line, last_in_group,
        output ready
    );
endinterface

interface slrs_res_if;
    logic                         valid;
    logic                         ready;
    logic [slrs_pkg::SUM_W-1:0]   best_on;
    logic [slrs_pkg::SUM_W-1:0]   best_off;

    modport source (
        output valid, best_on, best_off,
        input  ready
    );
    modport sink (
        input  valid, best_on, best_off,
        output ready
    );
endinterface

interface slrs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [slrs_pkg::CFG_IDX_W-1:0]   index;
    logic [slrs_pkg::CFG_W-1:0]       data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== hw/rtl/staff_line_run_score.sv =====
// Top level of the staff line run score block: run tracking, squaring and ratio compare.
//
//   Channel  Role     Carries
//   pix      sink     three pixel bits, last_in_line, last_in_group
//   res      source   best_on, best_off of a finished group
//   cfg      sink     index and data of a register write, always ready
//
// A pixel passes ST_TRANS and ST_INC, with ST_SQ_G to ST_AC_I between them when it closes a
// segment; a pixel of an aborted line is taken in ST_IDLE alone. A line end squares the
// trailing runs, then ST_FIX and ST_CMP_A to ST_CMP_C compare ratios; a group end adds ST_EMIT,
// which waits on res. Squaring and compare use the single shared 25x25 multiplier and its accumulator.
// No clearing pass follows reset; the block is ready on the first cycle.
// A result waiting in the output register holds up new pixels only when the next group end must emit.
`include "staff_line_run_score_macros.svh"

module staff_line_run_score #(
    parameter int MAX_LINE_LEN = slrs_pkg::MAX_LINE_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    slrs_pix_if.sink        pix,
    slrs_res_if.source      res,
    slrs_cfg_if.sink        cfg
);

    localparam int RUN_W  = $clog2(MAX_LINE_LEN + 1);
    localparam int CMP_W  = (RUN_W > slrs_pkg::CFG_W) ? RUN_W : slrs_pkg::CFG_W;
    localparam int SUM_W  = slrs_pkg::SUM_W;
    localparam int PROD_W = 2 * SUM_W;

    localparam logic [RUN_W-1:0] RUN_CAP   = RUN_W'(MAX_LINE_LEN);
    localparam logic [RUN_W:0]   RUN_CAP_X = (RUN_W + 1)'(MAX_LINE_LEN);
    localparam logic [RUN_W-1:0] RUN_ONE   = RUN_W'(1);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_TRANS = 13'b0000000000010,
        ST_SQ_G  = 13'b0000000000100,
        ST_AC_G  = 13'b0000000001000,
        ST_SQ_I  = 13'b0000000010000,
        ST_AC_I  = 13'b0000000100000,
        ST_INC   = 13'b0000001000000,
        ST_LEND  = 13'b0000010000000,
        ST_FIX   = 13'b0000100000000,
        ST_CMP_A = 13'b0001000000000,
        ST_CMP_B = 13'b0010000000000,
        ST_CMP_C = 13'b0100000000000,
        ST_EMIT  = 13'b1000000000000
    } state_t;

    function automatic logic [RUN_W-1:0] run_add(
        input logic [RUN_W-1:0] a,
        input logic [RUN_W-1:0] b
    );
        logic [RUN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > RUN_CAP_X) ? RUN_CAP : s[RUN_W-1:0];
    endfunction

    state_t                      state_reg, state_next;
    logic [slrs_pkg::CFG_W-1:0]  gap_min_reg, gap_abort_reg;
    logic                        ink_flag_reg, ink_flag_next;
    logic [RUN_W-1:0]            ink_run_reg, ink_run_next;
    logic [RUN_W-1:0]            gap_run_reg, gap_run_next;
    logic [SUM_W-1:0]            ink_sum_reg, ink_sum_next;
    logic [SUM_W-1:0]            gap_sum_reg, gap_sum_next;
    logic                        line_aborted_reg, line_aborted_next;
    logic [SUM_W-1:0]            best_num_reg, best_num_next;
    logic [SUM_W-1:0]            best_den_reg, best_den_next;
    logic                        ending_reg, ending_next;
    logic                        bit_reg, bit_next;
    logic                        end_line_reg, end_line_next;
    logic                        end_group_reg, end_group_next;
    logic [PROD_W-1:0]           prod_reg;
    logic [PROD_W-1:0]           lhs_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]            out_on_reg, out_on_next;
    logic [SUM_W-1:0]            out_off_reg, out_off_next;

    logic                        pix_take;
    logic [SUM_W-1:0]            mul_a, mul_b;
    logic [PROD_W-1:0]           mul_p;
    logic [SUM_W-1:0]            acc_in;
    logic [PROD_W:0]             acc_wide;
    logic [SUM_W-1:0]            acc_out;
    logic                        gap_gt_min;
    logic [RUN_W-1:0]            gap_new;
    logic                        out_free;

    assign pix.ready = (state_reg == ST_IDLE);
    assign pix_take  = pix.valid && pix.ready;
    assign cfg.ready = 1'b1;

    assign res.valid    = out_valid_reg;
    assign res.best_on  = out_on_reg;
    assign res.best_off = out_off_reg;
    assign out_free     = !out_valid_reg || res.ready;

    always_comb
    begin
        case (state_reg)
            ST_SQ_G:
            begin
                mul_a = SUM_W'(gap_run_reg);
                mul_b = SUM_W'(gap_run_reg);
            end
            ST_SQ_I:
            begin
                mul_a = SUM_W'(ink_run_reg);
                mul_b = SUM_W'(ink_run_reg);
            end
            ST_CMP_A:
            begin
                mul_a = ink_sum_reg;
                mul_b = best_den_reg;
            end
            ST_CMP_B:
            begin
                mul_a = best_num_reg;
                mul_b = gap_sum_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign acc_in   = (state_reg == ST_AC_G) ? gap_sum_reg : ink_sum_reg;
    assign acc_wide = (PROD_W + 1)'(acc_in) + (PROD_W + 1)'(prod_reg);
    assign acc_out  = (acc_wide > (PROD_W + 1)'(slrs_pkg::SUM_CAP)) ?
                      slrs_pkg::SUM_CAP : acc_wide[SUM_W-1:0];

    assign gap_gt_min = CMP_W'(gap_run_reg) > CMP_W'(gap_min_reg);
    assign gap_new    = bit_reg ? gap_run_reg : run_add(gap_run_reg, RUN_ONE);

    always_comb
    begin
        state_next        = state_reg;
        ink_flag_next     = ink_flag_reg;
        ink_run_next      = ink_run_reg;
        gap_run_next      = gap_run_reg;
        ink_sum_next      = ink_sum_reg;
        gap_sum_next      = gap_sum_reg;
        line_aborted_next = line_aborted_reg;
        best_num_next     = best_num_reg;
        best_den_next     = best_den_reg;
        ending_next       = ending_reg;
        bit_next          = bit_reg;
        end_line_next     = end_line_reg;
        end_group_next    = end_group_reg;
        out_valid_next    = out_valid_reg && !res.ready;
        out_on_next       = out_on_reg;
        out_off_next      = out_off_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pix_take)
                begin
                    bit_next       = pix.pixel_mid | pix.pixel_above | pix.pixel_below;
                    end_line_next  = pix.last_in_line;
                    end_group_next = pix.last_in_group;
                    if (!line_aborted_reg)
                        state_next = ST_TRANS;
                    else if (pix.last_in_line)
                        state_next = ST_LEND;
                    else if (pix.last_in_group)
                        state_next = ST_EMIT;
                end
            end
            ST_TRANS:
            begin
                state_next = ST_INC;
                if (bit_reg != ink_flag_reg)
                begin
                    if (!ink_flag_reg && gap_gt_min)
                    begin
                        ending_next = 1'b0;
                        state_next  = ST_SQ_G;
                    end
                    else
                    begin
                        if (!ink_flag_reg)
                        begin
                            ink_run_next = run_add(ink_run_reg, gap_run_reg);
                            gap_run_next = '0;
                        end
                        ink_flag_next = bit_reg;
                    end
                end
            end
            ST_SQ_G:
            begin
                state_next = ST_AC_G;
            end
            ST_AC_G:
            begin
                gap_sum_next = acc_out;
                state_next   = ST_SQ_I;
            end
            ST_SQ_I:
            begin
                state_next = ST_AC_I;
            end
            ST_AC_I:
            begin
                ink_sum_next = acc_out;
                if (ending_reg)
                    state_next = ST_FIX;
                else
                begin
                    ink_run_next  = '0;
                    gap_run_next  = '0;
                    ink_flag_next = bit_reg;
                    state_next    = ST_INC;
                end
            end
            ST_INC:
            begin
                if (bit_reg)
                    ink_run_next = run_add(ink_run_reg, RUN_ONE);
                gap_run_next = gap_new;
                if (CMP_W'(gap_new) > CMP_W'(gap_abort_reg))
                begin
                    line_aborted_next = 1'b1;
                    ink_run_next      = '0;
                    gap_run_next      = '0;
                    ink_sum_next      = '0;
                    gap_sum_next      = SUM_W'(1);
                end
                if (end_line_reg)
                    state_next = ST_LEND;
                else if (end_group_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_LEND:
            begin
                ending_next = 1'b1;
                if (gap_gt_min)
                    state_next = ST_SQ_G;
                else
                begin
                    ink_run_next = run_add(ink_run_reg, gap_run_reg);
                    state_next   = ST_SQ_I;
                end
            end
            ST_FIX:
            begin
                if (gap_sum_reg == '0)
                    gap_sum_next = SUM_W'(1);
                state_next = ST_CMP_A;
            end
            ST_CMP_A:
            begin
                state_next = ST_CMP_B;
            end
            ST_CMP_B:
            begin
                state_next = ST_CMP_C;
            end
            ST_CMP_C:
            begin
                if (lhs_reg > prod_reg)
                begin
                    best_num_next = ink_sum_reg;
                    best_den_next = gap_sum_reg;
                end
                ink_flag_next     = 1'b0;
                ink_run_next      = '0;
                gap_run_next      = '0;
                ink_sum_next      = '0;
                gap_sum_next      = '0;
                line_aborted_next = 1'b0;
                ending_next       = 1'b0;
                state_next        = end_group_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_on_next    = best_num_reg;
                    out_off_next   = best_den_reg;
                    best_num_next  = '0;
                    best_den_next  = SUM_W'(1);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            gap_min_reg      <= slrs_pkg::GAP_MIN_RST;
            gap_abort_reg    <= slrs_pkg::GAP_ABORT_RST;
            ink_flag_reg     <= 1'b0;
            ink_run_reg      <= '0;
            gap_run_reg      <= '0;
            ink_sum_reg      <= '0;
            gap_sum_reg      <= '0;
            line_aborted_reg <= 1'b0;
            best_num_reg     <= '0;
            best_den_reg     <= SUM_W'(1);
            ending_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ink_flag_reg     <= ink_flag_next;
            ink_run_reg      <= ink_run_next;
            gap_run_reg      <= gap_run_next;
            ink_sum_reg      <= ink_sum_next;
            gap_sum_reg      <= gap_sum_next;
            line_aborted_reg <= line_aborted_next;
            best_num_reg     <= best_num_next;
            best_den_reg     <= best_den_next;
            ending_reg       <= ending_next;
            out_valid_reg    <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    slrs_pkg::REG_GAP_MIN:   gap_min_reg   <= cfg.data;
                    slrs_pkg::REG_GAP_ABORT: gap_abort_reg <= cfg.data;
                    default:                 gap_min_reg   <= gap_min_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg       <= bit_next;
        end_line_reg  <= end_line_next;
        end_group_reg <= end_group_next;
        prod_reg      <= mul_p;
        if (state_reg == ST_CMP_B)
            lhs_reg <= prod_reg;
        out_on_reg    <= out_on_next;
        out_off_reg   <= out_off_next;
    end

    `SLRS_ASSERT(a_den_nonzero, clk, rst_n, best_den_reg != '0, "best denominator is zero")
    `SLRS_ASSERT(a_best_capped, clk, rst_n, (best_num_reg <= slrs_pkg::SUM_CAP) && (best_den_reg <= slrs_pkg::SUM_CAP), "best pair exceeds the sum cap")
    `SLRS_ASSERT(a_run_capped, clk, rst_n, (ink_run_reg <= RUN_CAP) && (gap_run_reg <= RUN_CAP), "run exceeds the line length cap")
    `SLRS_ASSERT_IMPL(a_abort_clear, clk, rst_n, line_aborted_reg, (ink_run_reg == '0) && (gap_run_reg == '0), "aborted line holds a nonzero run")

endmodule

// ===== tb/staff_line_run_score_checker.sv =====
// Checker of the staff line run score block: predicts the best ratio pair of each group and compares.
module staff_line_run_score_checker (
    input  logic clk,
    input  logic rst_n,
    slrs_pix_if  pix,
    slrs_res_if  res,
    slrs_cfg_if  cfg,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [13:0] RUN_CAP = 14'(slrs_pkg::MAX_LINE_LEN_DEF);

    typedef struct packed {
        logic [slrs_pkg::SUM_W-1:0] num;
        logic [slrs_pkg::SUM_W-1:0] den;
    } ratio_pair_t;

    logic [slrs_pkg::CFG_W-1:0] close_gap;
    logic [slrs_pkg::CFG_W-1:0] abort_gap;

    logic                       inked;
    logic [12:0]                ink_len;
    logic [12:0]                gap_len;
    logic [slrs_pkg::SUM_W-1:0] ink_sq;
    logic [slrs_pkg::SUM_W-1:0] gap_sq;
    logic                       dropped;
    logic [slrs_pkg::SUM_W-1:0] top_num;
    logic [slrs_pkg::SUM_W-1:0] top_den;

    ratio_pair_t best_pairs_due [$];
    int          fails = 0;

    function automatic logic [12:0] run_sat(input logic [12:0] a, input logic [12:0] b);
        logic [13:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > RUN_CAP)
            s = RUN_CAP;
        return s[12:0];
    endfunction

    function automatic logic [slrs_pkg::SUM_W-1:0] sq_acc(
        input logic [slrs_pkg::SUM_W-1:0] sum,
        input logic [12:0] run
    );
        logic [26:0] s;
        s = 27'(sum) + 27'(run) * 27'(run);
        if (s > 27'(slrs_pkg::SUM_CAP))
            s = 27'(slrs_pkg::SUM_CAP);
        return s[slrs_pkg::SUM_W-1:0];
    endfunction

    function automatic void clear_line_state();
        inked   = 1'b0;
        ink_len = '0;
        gap_len = '0;
        ink_sq  = '0;
        gap_sq  = '0;
        dropped = 1'b0;
    endfunction

    function automatic void score_pixel(input logic ink, input logic eol, input logic eog);
        if (!dropped)
        begin
            if (ink != inked)
            begin
                if (!inked)
                begin
                    if (gap_len > close_gap)
                    begin
                        gap_sq  = sq_acc(gap_sq, gap_len);
                        ink_sq  = sq_acc(ink_sq, ink_len);
                        ink_len = '0;
                    end
                    else
                    begin
                        ink_len = run_sat(ink_len, gap_len);
                    end
                    gap_len = '0;
                end
                inked = ink;
            end
            if (ink)
                ink_len = run_sat(ink_len, 13'd1);
            else
                gap_len = run_sat(gap_len, 13'd1);
            if (gap_len > abort_gap)
            begin
                dropped = 1'b1;
                ink_len = '0;
                gap_len = '0;
                ink_sq  = '0;
                gap_sq  = 25'd1;
            end
        end
        if (eol)
        begin
            if (gap_len > close_gap)
                gap_sq = sq_acc(gap_sq, gap_len);
            else
                ink_len = run_sat(ink_len, gap_len);
            ink_sq = sq_acc(ink_sq, ink_len);
            if (gap_sq == '0)
                gap_sq = 25'd1;
            if (50'(ink_sq) * 50'(top_den) > 50'(top_num) * 50'(gap_sq))
            begin
                top_num = ink_sq;
                top_den = gap_sq;
            end
            clear_line_state();
        end
        if (eog)
        begin
            best_pairs_due.push_back(ratio_pair_t'{num: top_num, den: top_den});
            top_num = '0;
            top_den = 25'd1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ratio_pair_t want;
        if (!rst_n)
        begin
            close_gap = slrs_pkg::GAP_MIN_RST;
            abort_gap = slrs_pkg::GAP_ABORT_RST;
            clear_line_state();
            top_num = '0;
            top_den = 25'd1;
            best_pairs_due.delete();
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (best_pairs_due.size() == 0)
                begin
                    $error("unexpected result: best_on %0d, best_off %0d",
                           res.best_on, res.best_off);
                    fails++;
                end
                else
                begin
                    want = best_pairs_due.pop_front();
                    if (res.best_on !== want.num)
                    begin
                        $error("best_on: expected %0d, actual %0d", want.num, res.best_on);
                        fails++;
                    end
                    if (res.best_off !== want.den)
                    begin
                        $error("best_off: expected %0d, actual %0d", want.den, res.best_off);
                        fails++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    slrs_pkg::REG_GAP_MIN:   close_gap = cfg.data;
                    slrs_pkg::REG_GAP_ABORT: abort_gap = cfg.data;
                    default:                 ;
                endcase
            end
            if (pix.valid && pix.ready)
                score_pixel(pix.pixel_mid | pix.pixel_above | pix.pixel_below,
                            pix.last_in_line, pix.last_in_group);
        end
        errors  <= fails;
        pending <= best_pairs_due.size();
    end

endmodule

// ===== tb/staff_line_run_score_test.sv =====
// Top of the staff line run score testbench: clock, reset, pixel and register stimulus, verdict.
module staff_line_run_score_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 500;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    slrs_pix_if pix ();
    slrs_res_if res ();
    slrs_cfg_if cfg ();

    int errors;
    int pending;

    int   burst_left   = 0;
    int   cur_close    = 20;
    int   cur_abort    = 100;
    logic squeeze_req  = 1'b0;
    logic squeeze_done = 1'b0;

    // Packed as {last_in_group, last_in_line, pixel_below, pixel_above, pixel_mid}.
    logic [4:0] directed_seq [0:26] = '{
        5'b00000, 5'b00001, 5'b00010, 5'b00100, 5'b00011, 5'b00101, 5'b00110, 5'b01111,
        5'b00001, 5'b00000, 5'b00000, 5'b00000, 5'b11010,
        5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b11100,
        5'b00001, 5'b10001, 5'b00001, 5'b00000, 5'b00000, 5'b01000, 5'b11111
    };

    staff_line_run_score uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .res   (res),
        .cfg   (cfg)
    );

    staff_line_run_score_checker ratio_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix),
        .res     (res),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    always #10 clk = ~clk;

    task automatic push_pixel(input logic [2:0] px, input logic eol, input logic eog);
        if (burst_left == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        pix.valid         <= 1'b1;
        pix.pixel_mid     <= px[0];
        pix.pixel_above   <= px[1];
        pix.pixel_below   <= px[2];
        pix.last_in_line  <= eol;
        pix.last_in_group <= eog;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic reconfigure(input int gap_close, input int gap_abort);
        pix.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= slrs_pkg::REG_GAP_MIN;
        cfg.data  <= slrs_pkg::CFG_W'(gap_close);
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.index <= slrs_pkg::REG_GAP_ABORT;
        cfg.data  <= slrs_pkg::CFG_W'(gap_abort);
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        cur_close = gap_close;
        cur_abort = gap_abort;
    endtask

    function automatic int gap_length();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(1, 4);
            1: v = (cur_close <= 40) ? cur_close + int'($urandom_range(0, 3)) - 1
                                     : $urandom_range(1, 6);
            2: v = (cur_abort <= 40) ? cur_abort + int'($urandom_range(0, 2))
                                     : $urandom_range(1, 6);
            default: v = $urandom_range(1, 30);
        endcase
        return (v < 1) ? 1 : v;
    endfunction

    task automatic send_group(input int max_lines, output int count);
        int         lines;
        int         runs;
        int         len;
        int         split;
        logic       inked;
        logic       eol;
        logic [2:0] px [$];
        count = 0;
        lines = $urandom_range(1, max_lines);
        for (int l = 0; l < lines; l++)
        begin
            px.delete();
            if ($urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(1, 30);
                repeat (len) px.push_back(3'($urandom()));
            end
            else
            begin
                inked = 1'($urandom());
                runs  = $urandom_range(1, 8);
                repeat (runs)
                begin
                    len = inked ? $urandom_range(1, 12) : gap_length();
                    repeat (len) px.push_back(inked ? 3'($urandom_range(1, 7)) : 3'b000);
                    inked = !inked;
                end
            end
            split = ($urandom_range(0, 7) == 0) ? $urandom_range(0, px.size() - 1) : -1;
            for (int i = 0; i < px.size(); i++)
            begin
                eol = (i == px.size() - 1);
                push_pixel(($urandom_range(0, 24) == 0) ? 3'($urandom()) : px[i], eol,
                           (eol && l == lines - 1) || i == split);
            end
            count += px.size();
        end
    endtask

    task automatic random_groups(input int budget);
        int sent;
        int n;
        sent = 0;
        while (sent < budget)
        begin
            send_group(4, n);
            sent += n;
        end
    endtask

    initial
    begin : result_sink
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                squeeze_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    0:       res.ready <= 1'b1;
                    1:       res.ready <= 1'($urandom_range(0, 1));
                    2:       res.ready <= ($urandom_range(0, 5) == 0);
                    default: res.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int n;
        pix.valid         <= 1'b0;
        pix.pixel_mid     <= 1'b0;
        pix.pixel_above   <= 1'b0;
        pix.pixel_below   <= 1'b0;
        pix.last_in_line  <= 1'b0;
        pix.last_in_group <= 1'b0;
        cfg.valid         <= 1'b0;
        cfg.index         <= slrs_pkg::REG_GAP_MIN;
        cfg.data          <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        random_groups(210);

        reconfigure(2, 5);
        foreach (directed_seq[i])
            push_pixel(directed_seq[i][2:0], directed_seq[i][3], directed_seq[i][4]);

        reconfigure(0, 0);
        random_groups(160);
        reconfigure(4095, 4095);
        random_groups(160);
        reconfigure(0, 4095);
        random_groups(130);
        reconfigure(4095, 0);
        random_groups(130);
        reconfigure(3, 9);
        random_groups(170);

        // Short groups while results are held back, so the output fills and the input stalls.
        reconfigure(1, 6);
        squeeze_req = 1'b1;
        while (!squeeze_done)
            send_group(1, n);
        random_groups(110);

        pix.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/slrs_pkg.sv
hw/rtl/slrs_if.sv
hw/rtl/staff_line_run_score.sv
tb/staff_line_run_score_checker.sv
tb/staff_line_run_score_test.sv
